>>> hdl/cdgf_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
package cdgf_pkg;

    // Column and depth geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DEPTH_W    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int GAP_CFG_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_JUMP = CFG_IDX_W'(1);

    localparam logic [GAP_CFG_W-1:0] MAX_GAP_RESET    = GAP_CFG_W'(24);
    localparam logic [DEPTH_W-1:0]   DEPTH_JUMP_RESET = DEPTH_W'(500);

    // Gap limit: the hard cap also bounds the results of one word at 32
    localparam int GAP_CAP_INT = 32;
    localparam logic [GAP_CFG_W-1:0] GAP_CAP = GAP_CFG_W'(GAP_CAP_INT);

    // Gap offset counter and divider sizes
    localparam int K_W       = $clog2(GAP_CAP_INT);
    localparam logic [K_W-1:0] LAST_GAP = K_W'(GAP_CAP_INT - 1);
    localparam int DVS_W     = GAP_CFG_W;
    localparam int DIV_W     = K_W + DEPTH_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Output word layout
    localparam int OUT_DATA_W = ((COL_W + DEPTH_W + 1 + 7) / 8) * 8;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic plan;
        logic div_start;
        logic div_step;
        logic load_gap;
        logic load_cur;
        logic commit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic gap_any;
        logic emit_cur;
        logic interp;
        logic gap_end;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

>>> hdl/column_depth_gap_filler_core.sv
// Top level: column depth gap filler, controller plus datapath.
// Per word: accept, plan, then each gap column emitted as invalid, nearest or linearly filled
//   (21-step bit-serial divider), then the word's own result unless the word is held;
//   each result load waits while the output register is stalled.
// One word is in work at a time; the output register lets the next word enter early.
// Reset (synchronous, active low) drops the anchor, zeroes the column index and
//   loads max_gap 24 and depth_jump 500.
module column_depth_gap_filler_core
    import cdgf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DEPTH_W-1:0]    s_axis_tdata,   // [15:0] depth
    input  logic                  s_axis_tlast,   // row_end
    input  logic                  s_axis_tuser,   // depth_valid
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [11:0] column, [27:12] filled_depth,
                                                  // [28] filled_valid, rest zero
    output logic                  m_axis_tlast,   // run_last
    output logic                  m_axis_tuser,   // row_done
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_sts;

    cdgf_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    cdgf_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_depth       (s_axis_tdata),
        .i_in_depth_valid (s_axis_tuser),
        .i_in_row_end     (s_axis_tlast),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (m_axis_tready),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (m_axis_tvalid),
        .o_out_data       (m_axis_tdata),
        .o_out_last       (m_axis_tlast),
        .o_out_user       (m_axis_tuser)
    );

endmodule

>>> hdl/cdgf_datapath.sv
// Datapath: row state, configuration registers, gap divider and output register.
module cdgf_datapath
    import cdgf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [DEPTH_W-1:0]    i_in_depth,
    input  logic                  i_in_depth_valid,
    input  logic                  i_in_row_end,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_status               o_sts,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_last,
    output logic                  o_out_user
);

    // Configuration
    logic [GAP_CFG_W-1:0] r_max_gap;
    logic [DEPTH_W-1:0]   r_depth_jump;

    // Row state
    logic [DEPTH_W-1:0]   r_anchor_depth;
    logic [COL_W-1:0]     r_anchor_index;
    logic                 r_anchor_present;
    logic [COL_W-1:0]     r_next_index;
    logic                 r_gap_over;

    // Current word
    logic [DEPTH_W-1:0]   r_z;
    logic                 r_valid;
    logic                 r_row_end;
    logic [COL_W-1:0]     r_c;

    // Gap walk and divider
    logic [K_W-1:0]       r_k;
    logic [DEPTH_W-1:0]   r_adiff;
    logic                 r_neg;
    logic [DVS_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Output register
    logic                 r_out_valid;
    logic [COL_W-1:0]     r_out_col;
    logic [DEPTH_W-1:0]   r_out_depth;
    logic                 r_out_fvalid;
    logic                 r_out_last;
    logic                 r_out_row_done;

    logic [COL_W-1:0]     w_d;
    logic                 w_holding;
    logic [GAP_CFG_W-1:0] w_g;
    logic                 w_flush;
    logic                 w_gap_fill;
    logic [K_W-1:0]       w_gap_cnt;
    logic                 w_emit_cur;
    logic [DEPTH_W:0]     w_diff;
    logic [DVS_W:0]       w_trial;
    logic                 w_ge;
    logic [DVS_W:0]       w_rem_sub;
    logic [DEPTH_W-1:0]   w_q;
    logic [DEPTH_W-1:0]   w_gap_depth;
    logic                 w_out_free;

    // Decide what the current word causes
    always_comb begin
        w_d        = r_c - r_anchor_index;
        w_holding  = r_anchor_present && !r_gap_over;
        w_g        = (r_max_gap > GAP_CAP) ? GAP_CAP : r_max_gap;
        w_flush    = w_holding && !r_valid &&
                     (r_row_end || (w_d == '0) || (w_d >= COL_W'(w_g)));
        w_gap_fill = r_valid && (w_d > COL_W'(1)) && (w_d <= COL_W'(w_g));
        if (!(w_holding && (r_valid || w_flush)) || (w_d == '0)) begin
            w_gap_cnt = '0;
        end else if (w_d >= COL_W'(GAP_CAP)) begin
            w_gap_cnt = LAST_GAP;
        end else begin
            w_gap_cnt = K_W'(w_d - COL_W'(1));
        end
        w_emit_cur = r_valid || !w_holding || w_flush;
        w_diff     = {1'b0, r_z} - {1'b0, r_anchor_depth};
    end

    // One restoring division step
    always_comb begin
        w_trial   = {r_rem, r_quo[DIV_W-1]};
        w_ge      = (w_trial >= {1'b0, w_d[DVS_W-1:0]});
        w_rem_sub = w_trial - {1'b0, w_d[DVS_W-1:0]};
    end

    // Pick the gap column depth
    always_comb begin
        w_q = r_quo[DEPTH_W-1:0];
        if (!w_gap_fill) begin
            w_gap_depth = '0;
        end else if (r_adiff <= r_depth_jump) begin
            w_gap_depth = r_neg ? (r_anchor_depth - w_q) : (r_anchor_depth + w_q);
        end else if (COL_W'({r_k, 1'b0}) <= w_d) begin
            w_gap_depth = r_anchor_depth;
        end else begin
            w_gap_depth = r_z;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.gap_any  = (w_gap_cnt != '0);
        o_sts.emit_cur = w_emit_cur;
        o_sts.interp   = w_gap_fill && (r_adiff <= r_depth_jump);
        o_sts.gap_end  = (r_k == w_gap_cnt);
        o_sts.div_last = (r_div_cnt == '0);
        o_sts.out_free = w_out_free;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap    <= MAX_GAP_RESET;
            r_depth_jump <= DEPTH_JUMP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_GAP:    r_max_gap    <= i_cfg_data[GAP_CFG_W-1:0];
                REG_DEPTH_JUMP: r_depth_jump <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Row state: update at the end of each word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_depth   <= '0;
            r_anchor_index   <= '0;
            r_anchor_present <= 1'b0;
            r_next_index     <= '0;
            r_gap_over       <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_valid) begin
                r_anchor_depth <= r_z;
                r_anchor_index <= r_c;
            end
            if (r_row_end) begin
                r_anchor_present <= 1'b0;
                r_gap_over       <= 1'b0;
                r_next_index     <= '0;
            end else begin
                if (r_valid) begin
                    r_anchor_present <= 1'b1;
                    r_gap_over       <= 1'b0;
                end else if (w_flush) begin
                    r_gap_over <= 1'b1;
                end
                r_next_index <= r_c + COL_W'(1);
            end
        end
    end

    // Capture the word, prepare the gap walk, run the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_z       <= i_in_depth;
            r_valid   <= i_in_depth_valid;
            r_row_end <= i_in_row_end;
            r_c       <= r_next_index;
        end
        if (i_cmd.plan) begin
            r_k     <= K_W'(1);
            r_neg   <= w_diff[DEPTH_W];
            r_adiff <= w_diff[DEPTH_W] ? DEPTH_W'(-w_diff) : w_diff[DEPTH_W-1:0];
        end else if (i_cmd.load_gap) begin
            r_k <= r_k + K_W'(1);
        end
        if (i_cmd.div_start) begin
            r_quo     <= DIV_W'(r_k * r_adiff);
            r_rem     <= '0;
            r_div_cnt <= DIV_CNT_W'(DIV_W - 1);
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[DIV_W-2:0], w_ge};
            r_rem     <= w_ge ? w_rem_sub[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_gap || i_cmd.load_cur) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_gap) begin
            r_out_col      <= r_anchor_index + COL_W'(r_k);
            r_out_depth    <= w_gap_depth;
            r_out_fvalid   <= w_gap_fill;
            r_out_last     <= 1'b0;
            r_out_row_done <= 1'b0;
        end else if (i_cmd.load_cur) begin
            r_out_col      <= r_c;
            r_out_depth    <= r_valid ? r_z : '0;
            r_out_fvalid   <= r_valid;
            r_out_last     <= 1'b1;
            r_out_row_done <= r_row_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_DATA_W'({r_out_fvalid, r_out_depth, r_out_col});
    assign o_out_last  = r_out_last;
    assign o_out_user  = r_out_row_done;

endmodule

>>> hdl/cdgf_controller.sv
// Controller: sequences accept, gap walk, division and result loads for each word.
module cdgf_controller
    import cdgf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_sts,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_GAP,
        ST_DIV,
        ST_GAP_OUT,
        ST_CUR
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PLAN;
                end
            end
            ST_PLAN: begin
                o_cmd.plan = 1'b1;
                if (i_sts.gap_any) begin
                    n_state = ST_GAP;
                end else if (i_sts.emit_cur) begin
                    n_state = ST_CUR;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_GAP: begin
                if (i_sts.interp) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_GAP_OUT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_GAP_OUT;
                end
            end
            ST_GAP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_gap = 1'b1;
                    n_state        = i_sts.gap_end ? ST_CUR : ST_GAP;
                end
            end
            ST_CUR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_cur = 1'b1;
                    o_cmd.commit   = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/cdgf_checker.sv
// Port checker for the gap filler core and its bind.
module cdgf_checker
    import cdgf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tlast,
    input  logic                  i_m_tuser
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output word changed while stalled");

    // Row end result always closes the word's run
    a_row_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tlast)
        else $error("row_done without run_last");

    // Invalid result carries zero depth
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tdata[COL_W+DEPTH_W] |-> i_m_tdata[COL_W+DEPTH_W-1:COL_W] == '0)
        else $error("invalid result with nonzero depth");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind column_depth_gap_filler_core cdgf_checker u_cdgf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast),
    .i_m_tuser  (m_axis_tuser)
);

>>> sim/tb_column_depth_gap_filler_core.sv
// Testbench for the column depth gap filler: directed table, random rows, scoreboard.
`timescale 1ns / 1ps

module tb_column_depth_gap_filler_core
    import cdgf_pkg::*;
();

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD = 300;
    localparam int LONG_HOLD_AFTER = 60;
    localparam int PAD_LSB = COL_W + DEPTH_W + 1;

    // One input column and one output result
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               present;
        logic               row_end;
    } t_column_in;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [DEPTH_W-1:0] depth;
        logic               valid;
        logic               run_last;
        logic               row_done;
    } t_fill_result;

    // Directed row: input word plus a typed result where it is obvious
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               present;
        logic               row_end;
        logic               typed;
        logic [COL_W-1:0]   col;
        logic [DEPTH_W-1:0] fill_depth;
        logic               fill_valid;
    } t_directed_row;

    localparam int DIRECTED_N = 22;
    localparam t_directed_row DIRECTED [DIRECTED_N] = '{
        // leading invalid column, then the depth extremes back to back
        '{16'h0000, 1'b0, 1'b0, 1'b1, 12'd0, 16'h0000, 1'b0},
        '{16'hFFFF, 1'b1, 1'b0, 1'b1, 12'd1, 16'hFFFF, 1'b1},
        '{16'h0000, 1'b1, 1'b0, 1'b1, 12'd2, 16'h0000, 1'b1},
        // short gap closed within depth_jump: linear fill
        '{16'h1234, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'hABCD, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'd300,  1'b1, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        // step above depth_jump: nearest endpoint, tie to the earlier one
        '{16'h0000, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'h5555, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'd2000, 1'b1, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        // falling slope: quotient truncated toward zero
        '{16'h0000, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'd1801, 1'b1, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        // trailing gap open at row end
        '{16'h7777, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b1, 1'b0, 12'd0, 16'h0000, 1'b0},
        // one-column rows
        '{16'h0000, 1'b0, 1'b1, 1'b1, 12'd0, 16'h0000, 1'b0},
        '{16'hFFFF, 1'b1, 1'b1, 1'b1, 12'd0, 16'hFFFF, 1'b1},
        // step exactly at depth_jump, then one above it
        '{16'h0000, 1'b1, 1'b0, 1'b1, 12'd0, 16'h0000, 1'b1},
        '{16'h0000, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'd500,  1'b1, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b0, 12'd0, 16'h0000, 1'b0},
        '{16'd1001, 1'b1, 1'b1, 1'b0, 12'd0, 16'h0000, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DEPTH_W-1:0]    s_axis_tdata;   // [15:0] depth
    logic                  s_axis_tlast;   // row_end
    logic                  s_axis_tuser;   // depth_valid
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [11:0] column, [27:12] filled_depth,
                                           // [28] filled_valid, rest zero
    logic                  m_axis_tlast;   // run_last
    logic                  m_axis_tuser;   // row_done
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    column_depth_gap_filler_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state and configuration
    logic [GAP_CFG_W-1:0] cfg_max_gap = MAX_GAP_RESET;
    logic [DEPTH_W-1:0]   cfg_jump    = DEPTH_JUMP_RESET;
    logic [DEPTH_W-1:0]   held_depth  = '0;
    logic [COL_W-1:0]     held_col    = '0;
    logic [COL_W-1:0]     next_col    = '0;
    bit                   have_anchor = 1'b0;
    bit                   gap_lost    = 1'b0;

    t_fill_result expected_fills [$];
    t_fill_result step_fills [$];
    t_column_in   stim_cols [$];

    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          cycle_count    = 0;
    int unsigned send_calm      = 0;
    int unsigned recv_calm      = 0;
    bit          long_hold_done = 1'b0;

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int gap_lim();
        return (int'(cfg_max_gap) > GAP_CAP_INT) ? GAP_CAP_INT : int'(cfg_max_gap);
    endfunction

    // Draw an idle count; now and then start a stretch with no idling
    function automatic int unsigned draw_idle(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic void add_fill(input logic [COL_W-1:0] col,
                                     input logic [DEPTH_W-1:0] depth, input logic valid);
        if (step_fills.size() < GAP_CAP_INT)
            step_fills.push_back('{col, depth, valid, 1'b0, 1'b0});
    endfunction

    // Work out the results one accepted column causes and advance the state
    function automatic void predict_fill(input t_column_in w);
        logic [COL_W-1:0] cur;
        logic [COL_W-1:0] span;
        int lim, span_len, k, z0, z1, diff, adiff;
        bit holding, fill;
        step_fills.delete();
        cur = next_col;
        lim = gap_lim();
        holding = have_anchor && !gap_lost;
        span = cur - held_col;
        span_len = holding ? int'(span) : 0;
        if (w.present) begin
            if (holding) begin
                fill = (span_len > 1) && (span_len <= lim);
                z0 = int'(held_depth);
                z1 = int'(w.depth);
                diff = z1 - z0;
                adiff = (diff < 0) ? -diff : diff;
                for (k = 1; k < span_len && k < GAP_CAP_INT; k++) begin
                    if (!fill)
                        add_fill(held_col + COL_W'(k), '0, 1'b0);
                    else if (adiff <= int'(cfg_jump))
                        add_fill(held_col + COL_W'(k),
                                 DEPTH_W'(z0 + (k * diff) / span_len), 1'b1);
                    else
                        add_fill(held_col + COL_W'(k),
                                 DEPTH_W'((k <= span_len - k) ? z0 : z1), 1'b1);
                end
            end
            add_fill(cur, w.depth, 1'b1);
            held_depth = w.depth;
            held_col = cur;
            have_anchor = 1'b1;
            gap_lost = 1'b0;
        end else if (holding) begin
            // release the held gap as invalid once it can no longer be closed
            if (w.row_end || span_len == 0 || span_len + 1 > lim) begin
                for (k = 1; k < ((span_len == 0) ? 1 : span_len) && k < GAP_CAP_INT; k++)
                    add_fill(held_col + COL_W'(k), '0, 1'b0);
                add_fill(cur, '0, 1'b0);
                gap_lost = 1'b1;
            end
        end else begin
            add_fill(cur, '0, 1'b0);
        end
        next_col = cur + COL_W'(1);
        if (w.row_end) begin
            have_anchor = 1'b0;
            gap_lost = 1'b0;
            next_col = '0;
        end
        if (step_fills.size() > 0) begin
            step_fills[$].run_last = 1'b1;
            step_fills[$].row_done = w.row_end;
        end
    endfunction

    function automatic void report_fill(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s", $time, msg);
    endfunction

    // Next valid depth: near the last one, at the jump boundary, far, or an extreme
    function automatic logic [DEPTH_W-1:0] next_depth(input int z);
        int step;
        case ($urandom_range(0, 5))
            0: return DEPTH_W'($urandom);
            1: return $urandom_range(0, 1) ? {DEPTH_W{1'b1}} : '0;
            2: step = int'(cfg_jump) + int'($urandom_range(0, 1));
            default: step = int'($urandom_range(0, int'(cfg_jump)));
        endcase
        if (step > 65535)
            step = 65535;
        if (z >= step && (z + step > 65535 || $urandom_range(0, 1) == 1))
            return DEPTH_W'(z - step);
        if (z + step <= 65535)
            return DEPTH_W'(z + step);
        return DEPTH_W'($urandom);
    endfunction

    // Queue rows of valid columns and gaps around the fill limit, with some noise
    task automatic queue_rows(input int n_items, input int min_row, input int max_row);
        int first, left, run, lim, row_left, i;
        logic [DEPTH_W-1:0] z;
        first = stim_cols.size();
        left = n_items;
        lim = gap_lim();
        z = DEPTH_W'($urandom);
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0: begin
                    stim_cols.push_back('{DEPTH_W'($urandom), 1'($urandom), 1'b0});
                    left--;
                end
                1, 2, 3: begin
                    case ($urandom_range(0, 3))
                        0, 1: run = 1 + int'($urandom_range(0, (lim > 2) ? lim - 2 : 0));
                        2: run = ((lim > 1) ? lim - 1 : 1) + int'($urandom_range(0, 2));
                        default: run = int'($urandom_range(1, 40));
                    endcase
                    if (run > left)
                        run = left;
                    repeat (run) stim_cols.push_back('{DEPTH_W'($urandom), 1'b0, 1'b0});
                    left -= run;
                end
                default: begin
                    z = next_depth(int'(z));
                    stim_cols.push_back('{z, 1'b1, 1'b0});
                    left--;
                end
            endcase
        end
        // cut into rows; the last column always ends its row
        row_left = $urandom_range(min_row, max_row);
        for (i = first; i < stim_cols.size(); i++) begin
            row_left--;
            stim_cols[i].row_end = (row_left == 0) || (i == stim_cols.size() - 1);
            if (row_left == 0)
                row_left = $urandom_range(min_row, max_row);
        end
    endtask

    // Offer one word after a random idle, predict on acceptance
    task automatic send_column(input t_column_in w, input bit typed,
                               input t_fill_result typed_fill);
        int unsigned idle;
        idle = draw_idle(send_calm);
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w.depth;
        s_axis_tuser <= w.present;
        s_axis_tlast <= w.row_end;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_fill(w);
        if (typed)
            expected_fills.push_back(typed_fill);
        else
            foreach (step_fills[i]) expected_fills.push_back(step_fills[i]);
        @(negedge i_clk);
    endtask

    task automatic drive_columns();
        while (stim_cols.size() > 0)
            send_column(stim_cols.pop_front(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait until every expected result is in, then let the block go quiet
    task automatic settle();
        while (expected_fills.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers on consecutive cycles
    task automatic write_regs(input logic [CFG_DATA_W-1:0] gap_word,
                              input logic [CFG_DATA_W-1:0] jump_word);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_MAX_GAP;
        i_cfg_data <= gap_word;
        @(negedge i_clk);
        i_cfg_idx <= REG_DEPTH_JUMP;
        i_cfg_data <= jump_word;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_max_gap = gap_word[GAP_CFG_W-1:0];
        cfg_jump = jump_word[DEPTH_W-1:0];
    endtask

    // Result sink: random stalls, one long hold, compare against the oldest expectation
    initial begin : result_sink
        int unsigned idle;
        t_fill_result got;
        t_fill_result want;
        logic [OUT_DATA_W-PAD_LSB-1:0] pad;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            idle = draw_idle(recv_calm);
            if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                idle = LONG_HOLD;
            end
            if (idle > 0) begin
                m_axis_tready <= 1'b0;
                repeat (idle) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results_seen++;
            got = '{m_axis_tdata[COL_W-1:0], m_axis_tdata[COL_W +: DEPTH_W],
                    m_axis_tdata[COL_W + DEPTH_W], m_axis_tlast, m_axis_tuser};
            pad = m_axis_tdata[OUT_DATA_W-1:PAD_LSB];
            if (expected_fills.size() == 0) begin
                report_fill($sformatf("unexpected result col=%0d depth=%0d valid=%b last=%b done=%b",
                                      got.column, got.depth, got.valid, got.run_last,
                                      got.row_done));
            end else begin
                want = expected_fills.pop_front();
                if (got !== want || pad !== '0)
                    report_fill($sformatf({"mismatch exp col=%0d depth=%0d valid=%b last=%b ",
                                           "done=%b / got col=%0d depth=%0d valid=%b last=%b ",
                                           "done=%b pad=%h"},
                                          want.column, want.depth, want.valid, want.run_last,
                                          want.row_done, got.column, got.depth, got.valid,
                                          got.run_last, got.row_done, pad));
            end
            @(negedge i_clk);
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] gap_words [4];
        logic [CFG_DATA_W-1:0] jump_words [4];
        t_directed_row r;
        gap_words = '{16'd0, 16'd1, 16'd2, 16'd33};
        jump_words = '{16'd0, 16'd1000, 16'd0, 16'd250};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MAX_GAP;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table at reset settings
        for (int i = 0; i < DIRECTED_N; i++) begin
            r = DIRECTED[i];
            send_column('{r.depth, r.present, r.row_end}, r.typed,
                        '{r.col, r.fill_depth, r.fill_valid, 1'b1, r.row_end});
        end
        s_axis_tvalid <= 1'b0;
        settle();

        // widest limit (upper bits dropped), full-range linear fill, most results per word
        write_regs(16'hFFFF, 16'hFFFF);
        stim_cols.push_back('{16'h0000, 1'b1, 1'b0});
        repeat (GAP_CAP_INT - 1) stim_cols.push_back('{DEPTH_W'($urandom), 1'b0, 1'b0});
        stim_cols.push_back('{16'hFFFF, 1'b1, 1'b1});
        queue_rows(4, 1, 30);
        drive_columns();
        settle();

        // limits that never fill, the smallest fill, jump of zero, limit above the cap
        for (int i = 0; i < 4; i++) begin
            write_regs(gap_words[i], jump_words[i]);
            queue_rows(7, 1, 30);
            drive_columns();
            settle();
        end

        // leave a gap open, then narrow the limit under it
        write_regs(16'hFFC8, 16'd500);
        queue_rows(8, 1, 30);
        stim_cols.push_back('{DEPTH_W'($urandom), 1'b1, 1'b0});
        stim_cols.push_back('{DEPTH_W'($urandom), 1'b0, 1'b0});
        stim_cols.push_back('{DEPTH_W'($urandom), 1'b0, 1'b0});
        drive_columns();
        settle();
        write_regs(16'd3, 16'd500);
        queue_rows(8, 1, 30);
        drive_columns();
        settle();

        // back to the reset settings
        write_regs(16'd24, 16'd500);
        queue_rows(8, 1, 30);
        drive_columns();
        settle();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
